[rtl/core/lusd_pkg.sv]
`default_nettype none

package lusd_pkg;

    localparam int BYTE_W     = 8;
    localparam int CP_W       = 21;
    localparam int MAX_RES    = 3;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int RES_CNT_W  = $clog2(MAX_RES + 1);
    localparam int HELD_W     = 2;

    localparam logic [CP_W-1:0]   REPLACEMENT = 21'h00FFFD;
    localparam logic [HELD_W-1:0] NEED_NONE   = 2'd0;
    localparam logic [HELD_W-1:0] NEED_ONE    = 2'd1;
    localparam logic [HELD_W-1:0] NEED_TWO    = 2'd2;
    localparam logic [HELD_W-1:0] NEED_THREE  = 2'd3;

    typedef struct packed {
        logic [RES_CNT_W-1:0]          count;
        logic [MAX_RES-1:0][CP_W-1:0]  code;
        logic [MAX_RES-1:0]            last;
    } res_bundle_t;

    function automatic logic [HELD_W-1:0] follow_count(input logic [BYTE_W-1:0] c);
        logic [HELD_W-1:0] n;
        n = NEED_NONE;
        if (c[7:5] == 3'b110) n = NEED_ONE;
        else if (c[7:4] == 4'b1110) n = NEED_TWO;
        else if (c[7:3] == 5'b11110) n = NEED_THREE;
        return n;
    endfunction

    function automatic logic [CP_W-1:0] single_byte(input logic [BYTE_W-1:0] c);
        logic [CP_W-1:0] v;
        if (c[7]) v = REPLACEMENT;
        else v = {{(CP_W-BYTE_W){1'b0}}, c};
        return v;
    endfunction

    function automatic logic [CP_W-1:0] assemble(
        input logic [BYTE_W-1:0] lead,
        input logic [BYTE_W-1:0] s0,
        input logic [BYTE_W-1:0] s1,
        input logic [BYTE_W-1:0] s2,
        input logic [HELD_W-1:0] need
    );
        logic [CP_W-1:0] v;
        case (need)
            NEED_ONE:   v = {10'd0, lead[4:0], s0[5:0]};
            NEED_TWO:   v = {5'd0, lead[3:0], s0[5:0], s1[5:0]};
            NEED_THREE: v = {lead[2:0], s0[5:0], s1[5:0], s2[5:0]};
            default:    v = REPLACEMENT;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/core/lusd_decode.sv]
`default_nettype none

module lusd_decode (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        fire,
    input  wire logic [lusd_pkg::BYTE_W-1:0] byte_val,
    input  wire logic                        last_val,
    output lusd_pkg::res_bundle_t            res
);
    import lusd_pkg::*;

    logic [BYTE_W-1:0] pending_lead_reg, pending_lead_next;
    logic              lead_valid_reg, lead_valid_next;
    logic [BYTE_W-1:0] held0_reg, held0_next;
    logic [BYTE_W-1:0] held1_reg, held1_next;
    logic [HELD_W-1:0] held_count_reg, held_count_next;

    always_comb
    begin
        logic [HELD_W-1:0] pend_need;
        logic [HELD_W-1:0] hc;
        logic [HELD_W-1:0] have;
        logic [HELD_W-1:0] need_b;
        logic [BYTE_W-1:0] s0, s1, s2;
        logic [RES_CNT_W-1:0] n;
        logic [MAX_RES-1:0][CP_W-1:0] r;

        pending_lead_next = pending_lead_reg;
        lead_valid_next   = lead_valid_reg;
        held0_next        = held0_reg;
        held1_next        = held1_reg;
        held_count_next   = held_count_reg;
        n = '0;
        r = {MAX_RES{REPLACEMENT}};

        pend_need = follow_count(pending_lead_reg);
        need_b    = follow_count(byte_val);
        hc   = (held_count_reg == 2'd3) ? 2'd2 : held_count_reg;
        have = hc + 2'd1;
        s0   = (hc == 2'd0) ? byte_val : held0_reg;
        s1   = (hc == 2'd1) ? byte_val : held1_reg;
        s2   = byte_val;

        if (lead_valid_reg && pend_need != NEED_NONE)
        begin
            if (have >= pend_need)
            begin
                r[0] = assemble(pending_lead_reg, s0, s1, s2, pend_need);
                n = 2'd1;
                lead_valid_next   = 1'b0;
                pending_lead_next = '0;
                held_count_next   = '0;
            end
            else if (last_val)
            begin
                r[0] = REPLACEMENT;
                if (have == 2'd1)
                begin
                    r[1] = single_byte(s0);
                    n = 2'd2;
                end
                else if (!s0[7])
                begin
                    r[1] = single_byte(s0);
                    r[2] = single_byte(s1);
                    n = 2'd3;
                end
                else if (follow_count(s0) == NEED_ONE)
                begin
                    r[1] = assemble(s0, s1, '0, '0, NEED_ONE);
                    n = 2'd2;
                end
                else
                begin
                    r[1] = REPLACEMENT;
                    r[2] = single_byte(s1);
                    n = 2'd3;
                end
            end
            else
            begin
                if (hc == 2'd0) held0_next = byte_val;
                else held1_next = byte_val;
                held_count_next = have;
            end
        end
        else
        begin
            lead_valid_next   = 1'b0;
            pending_lead_next = '0;
            held_count_next   = '0;
            if (!byte_val[7])
            begin
                r[0] = single_byte(byte_val);
                n = 2'd1;
            end
            else if (need_b != NEED_NONE && !last_val)
            begin
                pending_lead_next = byte_val;
                lead_valid_next   = 1'b1;
            end
            else
            begin
                r[0] = REPLACEMENT;
                n = 2'd1;
            end
        end

        if (last_val)
        begin
            lead_valid_next   = 1'b0;
            pending_lead_next = '0;
            held_count_next   = '0;
        end

        res.count = n;
        res.code  = r;
        for (int i = 0; i < MAX_RES; i++)
            res.last[i] = last_val && (n == RES_CNT_W'(i + 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_lead_reg <= '0;
            lead_valid_reg   <= 1'b0;
            held_count_reg   <= '0;
        end
        else if (fire)
        begin
            pending_lead_reg <= pending_lead_next;
            lead_valid_reg   <= lead_valid_next;
            held_count_reg   <= held_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            held0_reg <= held0_next;
            held1_reg <= held1_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/lusd_fifo.sv]
`default_nettype none

module lusd_fifo (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      push_en,
    input  wire lusd_pkg::res_bundle_t     push,
    output logic                           room,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [lusd_pkg::CP_W-1:0]      code_point,
    output logic                           last_point
);
    import lusd_pkg::*;

    logic [CP_W-1:0]  code_mem [FIFO_DEPTH];
    logic             last_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] push_n;
    logic             pop;

    assign pop    = out_valid && out_ready;
    assign push_n = push_en ? CNT_W'(push.count) : '0;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + push_n - CNT_W'(pop);
    end

    assign room       = count_reg <= CNT_W'(FIFO_DEPTH - MAX_RES);
    assign out_valid  = count_reg != '0;
    assign code_point = code_mem[rd_ptr_reg];
    assign last_point = last_mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RES; i++)
        begin
            if (push_en && (RES_CNT_W'(i) < push.count))
            begin
                code_mem[wr_ptr_reg + PTR_W'(i)] <= push.code[i];
                last_mem[wr_ptr_reg + PTR_W'(i)] <= push.last[i];
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/lax_utf8_stream_decoder.sv]
// Lax UTF-8 decoder: takes one byte per cycle on the in channel and delivers
// 21-bit code points on the out channel, with last_point on the final code
// point of each string. A byte is captured in an input register, decoded
// from that register once the queue has room, and its results (zero to three)
// are written into a four-entry result queue that drives the outputs; the
// first result of a byte thus passes the input register and the queue before
// it is offered on the out channel. The sustained rate is one byte per cycle
// while the out side takes results as they come; the input stalls only while
// more than one result waits in the queue, which happens after the up to
// three results of an end-of-string flush.
`default_nettype none

module lax_utf8_stream_decoder (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [lusd_pkg::BYTE_W-1:0] byte_in,
    input  wire logic                        last_byte,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [lusd_pkg::CP_W-1:0]        code_point,
    output logic                             last_point
);
    import lusd_pkg::*;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;
    logic              room;
    logic              advance;
    res_bundle_t       res;

    assign advance  = in_valid_reg && room;
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_valid && in_ready)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= byte_in;
            last_reg <= last_byte;
        end
    end

    lusd_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (advance),
        .byte_val (byte_reg),
        .last_val (last_reg),
        .res      (res)
    );

    lusd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_en    (advance),
        .push       (res),
        .room       (room),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .code_point (code_point),
        .last_point (last_point)
    );

endmodule

`default_nettype wire

[rtl/core/lusd_checker.sv]
`default_nettype none

module lusd_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic                        in_ready,
    input  wire logic                        out_valid,
    input  wire logic                        out_ready,
    input  wire logic [lusd_pkg::CP_W-1:0]   code_point,
    input  wire logic                        last_point
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result request dropped before it was taken");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(code_point) && $stable(last_point))
        else $error("stalled result changed");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result waiting");

    a_first_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result appeared without a byte request two cycles before");

endmodule

bind lax_utf8_stream_decoder lusd_checker u_lusd_checker (.*);

`default_nettype wire

[bench/utf8_decode_check.sv]
`timescale 1ns / 100ps

module utf8_decode_check
    import lusd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_ready,
    input  wire logic [BYTE_W-1:0] byte_in,
    input  wire logic              last_byte,
    input  wire logic              out_valid,
    input  wire logic              out_ready,
    input  wire logic [CP_W-1:0]   code_point,
    input  wire logic              last_point,
    output int                     fail_count,
    output int                     points_waiting
);

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            fin;
    } point_t;

    point_t            points_due [$];
    point_t            burst_q [$];
    logic [BYTE_W-1:0] lead_q;
    logic              open_q;
    logic [BYTE_W-1:0] cont_q [2];
    int unsigned       cont_n;
    int                fail_n;

    function automatic int unsigned cont_needed(input logic [BYTE_W-1:0] c);
        if (c[7:5] == 3'b110)
            return 1;
        if (c[7:4] == 4'b1110)
            return 2;
        if (c[7:3] == 5'b11110)
            return 3;
        return 0;
    endfunction

    function automatic logic [CP_W-1:0] join_point(
        input logic [BYTE_W-1:0] lead,
        input logic [BYTE_W-1:0] s0,
        input logic [BYTE_W-1:0] s1,
        input logic [BYTE_W-1:0] s2,
        input int unsigned       n
    );
        logic [CP_W-1:0]   v;
        logic [BYTE_W-1:0] s [3];
        int unsigned       k;
        s[0] = s0;
        s[1] = s1;
        s[2] = s2;
        case (n)
            1:       v = CP_W'(lead & 8'h1F);
            2:       v = CP_W'(lead & 8'h0F);
            default: v = CP_W'(lead & 8'h07);
        endcase
        for (k = 0; k < n; k++)
            v = (v << 6) | CP_W'(s[k] & 8'h3F);
        return v;
    endfunction

    function automatic void add_point(input logic [CP_W-1:0] cp);
        point_t p;
        if (burst_q.size() < MAX_RES)
        begin
            p.cp  = cp;
            p.fin = 1'b0;
            burst_q = {burst_q, p};
        end
    endfunction

    task automatic predict_byte(input logic [BYTE_W-1:0] b, input logic fin);
        logic [BYTE_W-1:0] seq [5];
        logic [BYTE_W-1:0] c;
        int unsigned       need;
        int unsigned       have;
        int unsigned       i;
        burst_q.delete();
        for (i = 0; i < 5; i++)
            seq[i] = '0;
        // drop an open sequence whose lead takes no continuation
        if (open_q && cont_needed(lead_q) == 0)
            open_q = 1'b0;
        if (open_q)
        begin
            need = cont_needed(lead_q);
            have = (cont_n > 2) ? 2 : cont_n;
            for (i = 0; i < have; i++)
                seq[i] = cont_q[i];
            seq[have] = b;
            have++;
            if (have >= need)
            begin
                add_point(join_point(lead_q, seq[0], seq[1], seq[2], need));
                open_q = 1'b0;
                cont_n = 0;
            end
            else if (fin)
            begin
                add_point(REPLACEMENT);
                i = 0;
                while (i < have)
                begin
                    c = seq[i];
                    i++;
                    need = cont_needed(c);
                    if (!c[7])
                        add_point(CP_W'(c));
                    else if (need > 0 && have - i >= need)
                    begin
                        add_point(join_point(c, seq[i], seq[i+1], seq[i+2], need));
                        i += need;
                    end
                    else
                        add_point(REPLACEMENT);
                end
                open_q = 1'b0;
                cont_n = 0;
            end
            else
            begin
                cont_q[have-1] = b;
                cont_n = have;
            end
        end
        else
        begin
            need = cont_needed(b);
            if (!b[7])
                add_point(CP_W'(b));
            else if (need > 0 && !fin)
            begin
                lead_q = b;
                open_q = 1'b1;
                cont_n = 0;
            end
            else
                add_point(REPLACEMENT);
        end
        if (fin)
        begin
            open_q = 1'b0;
            lead_q = '0;
            cont_n = 0;
            if (burst_q.size() > 0)
                burst_q[burst_q.size()-1].fin = 1'b1;
        end
        points_due = {points_due, burst_q};
    endtask

    task automatic check_point();
        point_t due;
        if (points_due.size() == 0)
        begin
            fail_n++;
            if (fail_n <= 10)
                $display("unexpected code point %h last_point %b", code_point, last_point);
        end
        else
        begin
            due = points_due.pop_front();
            if (code_point !== due.cp || last_point !== due.fin)
            begin
                fail_n++;
                if (fail_n <= 10)
                    $display("code point mismatch: expected %h last %b, got %h last %b",
                             due.cp, due.fin, code_point, last_point);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_q = '0;
            open_q = 1'b0;
            cont_q[0] = '0;
            cont_q[1] = '0;
            cont_n = 0;
            fail_n = 0;
            points_due.delete();
            fail_count <= 0;
            points_waiting <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_byte(byte_in, last_byte);
            if (out_valid && out_ready)
                check_point();
            fail_count <= fail_n;
            points_waiting <= points_due.size();
        end
    end

endmodule

[bench/tb_lax_utf8_stream_decoder.sv]
`timescale 1ns / 100ps

module tb_lax_utf8_stream_decoder;
    import lusd_pkg::*;

    localparam int ITEM_TARGET = 210;
    localparam int CALM_AFTER  = 170;
    localparam int CYCLE_LIMIT = 200000;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [BYTE_W-1:0] byte_in;
    logic              last_byte;
    logic              out_valid;
    logic              out_ready;
    logic [CP_W-1:0]   code_point;
    logic              last_point;
    int                fail_count;
    int                points_waiting;

    bit                calm;
    bit                choke;
    int                requests_sent;
    int                gap_pct;
    int                cycles;
    logic [BYTE_W-1:0] text_q [$];
    logic [8:0]        directed_q [$];

    lax_utf8_stream_decoder DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .byte_in    (byte_in),
        .last_byte  (last_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .code_point (code_point),
        .last_point (last_point)
    );

    utf8_decode_check u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .byte_in        (byte_in),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .code_point     (code_point),
        .last_point     (last_point),
        .fail_count     (fail_count),
        .points_waiting (points_waiting)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    initial
        cycles = 0;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin);
        in_valid  <= 1'b1;
        byte_in   <= b;
        last_byte <= fin;
        @(posedge clk);
        // hold the request until the block takes it
        while (!in_ready)
            @(posedge clk);
        requests_sent++;
        if (!calm && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19))
                @(posedge clk);
        end
    endtask

    function automatic logic [BYTE_W-1:0] cont_byte();
        logic [BYTE_W-1:0] r;
        r = BYTE_W'($urandom);
        if ($urandom_range(0, 7) != 0)
            r = 8'h80 | (r & 8'h3F);
        return r;
    endfunction

    task automatic make_string();
        int                units;
        int                kind;
        logic [BYTE_W-1:0] r;
        text_q.delete();
        units = $urandom_range(1, 6);
        repeat (units)
        begin
            kind = $urandom_range(0, 9);
            r = BYTE_W'($urandom);
            if (kind <= 2)
                text_q = {text_q, r & 8'h7F};
            else if (kind <= 4)
            begin
                text_q = {text_q, 8'hC0 | (r & 8'h1F)};
                text_q = {text_q, cont_byte()};
            end
            else if (kind <= 6)
            begin
                text_q = {text_q, 8'hE0 | (r & 8'h0F)};
                text_q = {text_q, cont_byte()};
                text_q = {text_q, cont_byte()};
            end
            else if (kind == 7)
            begin
                text_q = {text_q, 8'hF0 | (r & 8'h07)};
                text_q = {text_q, cont_byte()};
                text_q = {text_q, cont_byte()};
                text_q = {text_q, cont_byte()};
            end
            else
                text_q = {text_q, r};
        end
        // cut the tail so the string may end inside a sequence
        if (text_q.size() > 2 && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2))
                void'(text_q.pop_back());
    endtask

    initial
    begin
        out_ready <= 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (calm)
                out_ready <= 1'b1;
            else if (choke)
            begin
                out_ready <= 1'b0;
                repeat (90)
                    @(posedge clk);
                choke = 1'b0;
                out_ready <= 1'b1;
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 19))
                    @(posedge clk);
                out_ready <= 1'b1;
                repeat ($urandom_range(0, 40))
                    @(posedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid <= 1'b0;
        byte_in <= '0;
        last_byte <= 1'b0;
        calm = 1'b0;
        choke = 1'b0;
        requests_sent = 0;
        gap_pct = 15;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bit 8 carries last_byte
        directed_q = '{9'h000, 9'h07F, 9'h080, 9'h0FF,
                       9'h0C3, 9'h0A9,
                       9'h0E2, 9'h082, 9'h0AC,
                       9'h0F7, 9'h0FF, 9'h0FF, 9'h0FF,
                       9'h0C2, 9'h041,
                       9'h1C2,
                       9'h0E2, 9'h182,
                       9'h0F0, 9'h0C3, 9'h1A9,
                       9'h0F0, 9'h041, 9'h142,
                       9'h1C1};
        foreach (directed_q[k])
            send_byte(directed_q[k][7:0], directed_q[k][8]);

        choke = 1'b1;
        while (requests_sent < ITEM_TARGET)
        begin
            if (requests_sent >= CALM_AFTER)
                calm = 1'b1;
            gap_pct = ($urandom_range(0, 3) == 0) ? 0 : 15;
            make_string();
            foreach (text_q[k])
                send_byte(text_q[k], k == text_q.size() - 1);
        end
        in_valid <= 1'b0;
        calm = 1'b1;

        @(posedge clk);
        while (points_waiting != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);
        if (fail_count == 0 && points_waiting == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[sim.f]
rtl/core/lusd_pkg.sv
rtl/core/lusd_decode.sv
rtl/core/lusd_fifo.sv
rtl/core/lax_utf8_stream_decoder.sv
rtl/core/lusd_checker.sv
bench/utf8_decode_check.sv
bench/tb_lax_utf8_stream_decoder.sv
